// File: design/trs_pkg.sv
package trs_pkg;

    // Default table geometry
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_WORD_WIDTH  = 32;

    // Fixed field widths on the channels
    localparam int FIELD_W  = 32;
    localparam int SLOT_W   = 8;
    localparam int ACTION_W = 2;

    // Search bounds: 0..255 plus one step outside on either side
    localparam int IDX_W = SLOT_W + 2;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_WRITE   = 2'd0;
    localparam action_t ACT_BSEARCH = 2'd1;
    localparam action_t ACT_LSEARCH = 2'd2;
    localparam action_t ACT_IGNORE  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef enum logic {
        MODE_BINARY,
        MODE_LINEAR
    } mode_t;

endpackage

// File: design/trs_req_if.sv
interface trs_req_if;
    import trs_pkg::*;

    logic                       valid;
    logic                       ready;
    action_t                    action;
    logic [SLOT_W-1:0]          slot;
    logic signed [FIELD_W-1:0]  entry_value;
    logic signed [FIELD_W-1:0]  key;
    logic [SLOT_W-1:0]          range_first;
    logic [SLOT_W-1:0]          range_last;

    modport source
    (
        output valid, action, slot, entry_value, key, range_first, range_last,
        input  ready
    );

    modport sink
    (
        input  valid, action, slot, entry_value, key, range_first, range_last,
        output ready
    );
endinterface

// File: design/trs_resp_if.sv
interface trs_resp_if;
    import trs_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] position;

    modport source
    (
        output valid, found, position,
        input  ready
    );

    modport sink
    (
        input  valid, found, position,
        output ready
    );
endinterface

// File: design/table_range_search_core.sv
// Table range search core.
// The req channel carries one transaction per operation: a write stores
// entry_value at slot and gives no response; a binary or linear search looks
// for key within slots range_first..range_last (last below first is empty).
// Each search gives one transaction on the resp channel with found and
// position (position is 0 when not found). Action code 3 is dropped.
// A write leaves the core idle, so the next transaction may follow at once.
// A search holds req.ready low until its result is in the output register:
// it probes in ST_SEARCH, one table read per probe, then loads the result in
// ST_DONE, after which req.ready returns high and resp.valid rises together;
// an empty range goes straight to ST_DONE with no probe. Each probe uses the
// one read port of the synchronous table memory, whose read data is compared
// and the next address issued in the same cycle.
// The result waits in the output register while resp.ready is low; a further
// search may run meanwhile and then holds until that register frees up.
// Reset clears the control state only; table contents stay undefined until
// written, and reading an unwritten slot gives an undefined answer.
module table_range_search_core #(
    parameter int TABLE_DEPTH = trs_pkg::DEF_TABLE_DEPTH,
    parameter int WORD_WIDTH  = trs_pkg::DEF_WORD_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    trs_req_if.sink    req,
    trs_resp_if.source resp
);
    import trs_pkg::*;

    localparam int ADDR_W               = $clog2(TABLE_DEPTH);
    localparam int HI_MAX_I             = (TABLE_DEPTH - 1 < 255) ? TABLE_DEPTH - 1 : 255;
    localparam logic [SLOT_W-1:0] HI_MAX = SLOT_W'(HI_MAX_I);
    localparam logic [16:0] DEPTH_LIM    = 17'(TABLE_DEPTH);

    state_t state_reg, state_next;
    mode_t  mode_reg;

    logic signed [IDX_W-1:0]      lo_reg, hi_reg, idx_reg;
    logic signed [WORD_WIDTH-1:0] key_reg;
    logic                         hit_reg;
    logic [SLOT_W-1:0]            pos_reg;
    logic                         out_valid_reg;
    logic                         out_found_reg;
    logic [SLOT_W-1:0]            out_pos_reg;

    logic                         accept;
    logic                         start_search;
    logic signed [IDX_W-1:0]      start_lo, start_hi, start_idx;
    logic signed [IDX_W:0]        start_sum;
    logic                         start_empty;
    logic [SLOT_W-1:0]            last_sat;

    logic signed [WORD_WIDTH-1:0] rd_data;
    logic                         word_match, key_less;
    logic signed [IDX_W-1:0]      lo_step, hi_step, idx_step;
    logic signed [IDX_W:0]        step_sum;
    logic                         step_done, step_hit;

    logic                         out_free;
    logic                         wr_en, rd_en;
    logic [ADDR_W-1:0]            rd_addr;

    assign accept       = req.valid && req.ready;
    assign start_search = accept && (req.action == ACT_BSEARCH || req.action == ACT_LSEARCH);
    assign out_free     = !out_valid_reg || resp.ready;

    // Saturate the range to the table and pick the first probe
    always_comb
    begin
        last_sat    = (req.range_last > HI_MAX) ? HI_MAX : req.range_last;
        start_lo    = $signed(IDX_W'(req.range_first));
        start_hi    = $signed(IDX_W'(last_sat));
        start_empty = start_hi < start_lo;
        start_sum   = (IDX_W+1)'(start_lo) + (IDX_W+1)'(start_hi);
        if (req.action == ACT_BSEARCH)
        begin
            start_idx = start_sum[IDX_W:1];
        end
        else
        begin
            start_idx = start_lo;
        end
    end

    // Compare the probed word and choose the next probe
    always_comb
    begin
        word_match = rd_data == key_reg;
        key_less   = key_reg < rd_data;
        lo_step    = lo_reg;
        hi_step    = hi_reg;
        step_hit   = word_match;
        step_done  = word_match;
        step_sum   = '0;
        unique case (mode_reg)
            MODE_BINARY:
            begin
                if (key_less)
                begin
                    hi_step = idx_reg - IDX_W'(1);
                end
                else
                begin
                    lo_step = idx_reg + IDX_W'(1);
                end
                if (hi_step < lo_step)
                begin
                    step_done = 1'b1;
                end
                step_sum = (IDX_W+1)'(lo_step) + (IDX_W+1)'(hi_step);
                idx_step = step_sum[IDX_W:1];
            end
            MODE_LINEAR:
            begin
                if (idx_reg == hi_reg)
                begin
                    step_done = 1'b1;
                end
                idx_step = idx_reg + IDX_W'(1);
            end
            default:
            begin
                idx_step = idx_reg;
            end
        endcase
    end

    // Table access: writes only while idle, reads only for a search
    always_comb
    begin
        wr_en = accept && req.action == ACT_WRITE && 17'(req.slot) < DEPTH_LIM;
        if (state_reg == ST_IDLE)
        begin
            rd_en   = start_search && !start_empty;
            rd_addr = ADDR_W'(start_idx[IDX_W-2:0]);
        end
        else
        begin
            rd_en   = state_reg == ST_SEARCH && !step_done;
            rd_addr = ADDR_W'(idx_step[IDX_W-2:0]);
        end
    end

    trs_table #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (WORD_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(req.slot)),
        .wr_data (WORD_WIDTH'(req.entry_value)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_search)
                begin
                    state_next = start_empty ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (step_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Channel outputs
    always_comb
    begin
        req.ready     = state_reg == ST_IDLE;
        resp.valid    = out_valid_reg;
        resp.found    = out_found_reg;
        resp.position = out_pos_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start_search)
        begin
            mode_reg <= (req.action == ACT_BSEARCH) ? MODE_BINARY : MODE_LINEAR;
            key_reg  <= WORD_WIDTH'(req.key);
            lo_reg   <= start_lo;
            hi_reg   <= start_hi;
            idx_reg  <= start_idx;
            hit_reg  <= 1'b0;
            pos_reg  <= '0;
        end
        else if (state_reg == ST_SEARCH)
        begin
            if (step_done)
            begin
                hit_reg <= step_hit;
                pos_reg <= step_hit ? idx_reg[SLOT_W-1:0] : '0;
            end
            else
            begin
                lo_reg  <= lo_step;
                hi_reg  <= hi_step;
                idx_reg <= idx_step;
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_found_reg <= hit_reg;
            out_pos_reg   <= pos_reg;
        end
    end

`ifndef SYNTHESIS
    // A result appears only out of the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp.valid) |-> $past(state_reg == ST_DONE))
        else $error("response raised without a finished search");

    // Every probe lies inside the live search range
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> lo_reg <= idx_reg && idx_reg <= hi_reg)
        else $error("probe index outside search range");

    // A miss always reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && !resp.found |-> resp.position == '0)
        else $error("miss with nonzero position");

    // A hit points into the table
    assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp.found |-> 17'(resp.position) < DEPTH_LIM)
        else $error("hit position beyond table");

    // No table write while a search is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !wr_en)
        else $error("table written during a search");
`endif

endmodule

// File: design/trs_table.sv
module trs_table #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic signed [WIDTH-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic signed [WIDTH-1:0] rd_data
);

    logic signed [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/sv/tb_table_range_search_core.sv
`timescale 1ns / 100ps

module tb_table_range_search_core;
    import trs_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PRINT_LIMIT  = 200;

    typedef struct packed
    {
        logic              found;
        logic [SLOT_W-1:0] position;
    } lookup_t;

    logic clk;
    logic rst_n;

    trs_req_if  req_bus();
    trs_resp_if resp_bus();

    table_range_search_core DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .resp  (resp_bus)
    );

    // Shadow copy of the table, updated as write transactions are accepted
    logic signed [FIELD_W-1:0] table_model [DEPTH];
    lookup_t                   pending_lookups [$];
    lookup_t                   want_lookup;
    int                        mismatch_count = 0;
    int                        cycle_count    = 0;
    bit                        steady         = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stall the result channel at random, except during a steady stretch
    always @(negedge clk)
    begin
        resp_bus.ready <= steady || ($urandom_range(0, 99) >= 24);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("MISMATCH at cycle %0d: %s got %0d, expected %0d",
                     cycle_count, what, got, want);
        end
    endtask

    // Compare each result transaction against the oldest pending lookup
    always @(posedge clk)
    begin
        if (rst_n && resp_bus.valid === 1'b1 && resp_bus.ready === 1'b1)
        begin
            if (pending_lookups.size() == 0)
            begin
                report_mismatch("result with no search pending, found",
                                32'(resp_bus.found), 0);
            end
            else
            begin
                want_lookup = pending_lookups.pop_front();
                if (resp_bus.found !== want_lookup.found)
                begin
                    report_mismatch("found", 32'(resp_bus.found),
                                    32'(want_lookup.found));
                end
                if (resp_bus.position !== want_lookup.position)
                begin
                    report_mismatch("position", 32'(resp_bus.position),
                                    32'(want_lookup.position));
                end
            end
        end
    end

    // Work out the lookup result against the shadow table
    function automatic lookup_t predict_lookup(input action_t act,
                                               input logic signed [FIELD_W-1:0] k,
                                               input logic [SLOT_W-1:0] first,
                                               input logic [SLOT_W-1:0] last);
        int      lo;
        int      hi;
        int      mid;
        int      idx;
        lookup_t res;

        res = '0;
        lo  = int'(first);
        hi  = int'(last);
        if (act == ACT_BSEARCH)
        begin
            // Halve the range, midpoint rounded down, first probe hit wins
            while (hi >= lo)
            begin
                mid = (lo + hi) / 2;
                if (table_model[SLOT_W'(mid)] == k)
                begin
                    res.found    = 1'b1;
                    res.position = SLOT_W'(mid);
                    break;
                end
                if (k < table_model[SLOT_W'(mid)])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        else
        begin
            // Scan upward, lowest match wins
            for (idx = lo; idx <= hi; idx++)
            begin
                if (table_model[SLOT_W'(idx)] == k)
                begin
                    res.found    = 1'b1;
                    res.position = SLOT_W'(idx);
                    break;
                end
            end
        end
        return res;
    endfunction

    // Insert an idle gap on the request side now and then
    task automatic pause_sender();
        if (!steady && $urandom_range(0, 99) < 24)
        begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    endtask

    // Send one request transaction; fields the action does not use carry noise
    task automatic send_op(input action_t act,
                           input logic [SLOT_W-1:0] slot,
                           input logic signed [FIELD_W-1:0] value,
                           input logic signed [FIELD_W-1:0] k,
                           input logic [SLOT_W-1:0] first,
                           input logic [SLOT_W-1:0] last);
        bit is_write;
        bit is_search;

        is_write  = (act == ACT_WRITE);
        is_search = (act == ACT_BSEARCH) || (act == ACT_LSEARCH);
        @(negedge clk);
        req_bus.valid       <= 1'b1;
        req_bus.action      <= act;
        req_bus.slot        <= is_write  ? slot  : SLOT_W'($urandom);
        req_bus.entry_value <= is_write  ? value : FIELD_W'($urandom);
        req_bus.key         <= is_search ? k     : FIELD_W'($urandom);
        req_bus.range_first <= is_search ? first : SLOT_W'($urandom);
        req_bus.range_last  <= is_search ? last  : SLOT_W'($urandom);

        // Hold until accepted
        @(posedge clk);
        while (req_bus.ready !== 1'b1) @(posedge clk);

        if (is_write)
            table_model[slot] = value;
        else if (is_search)
            pending_lookups.push_back(predict_lookup(act, k, first, last));

        pause_sender();
    endtask

    // Fill the whole table in ascending order, with runs of duplicates
    task automatic fill_sorted(input longint start_value, input int unsigned max_step);
        longint acc;
        int     s;

        acc = start_value;
        for (s = 0; s < DEPTH; s++)
        begin
            if (s > 0 && $urandom_range(0, 7) != 0)
                acc += longint'($urandom_range(0, max_step));
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            send_op(ACT_WRITE, SLOT_W'(s), FIELD_W'(acc), '0, '0, '0);
        end
    endtask

    // One search with a random range and a key that mostly sits in the table
    task automatic random_search();
        action_t                   act;
        logic [SLOT_W-1:0]         first;
        logic [SLOT_W-1:0]         last;
        logic signed [FIELD_W-1:0] k;
        int                        pick;

        act  = $urandom_range(0, 1) ? ACT_BSEARCH : ACT_LSEARCH;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            first = SLOT_W'($urandom_range(1, 255));
            last  = SLOT_W'($urandom_range(0, first - 1));
        end
        else if (pick < 15)
        begin
            first = '0;
            last  = '1;
        end
        else if (pick < 60)
        begin
            first = SLOT_W'($urandom_range(0, 255));
            last  = (first > 240) ? 8'd255 : SLOT_W'(first + $urandom_range(0, 15));
        end
        else
        begin
            first = SLOT_W'($urandom_range(0, 255));
            last  = SLOT_W'($urandom_range(first, 255));
        end

        pick = $urandom_range(0, 99);
        if (pick < 60 && last >= first)
            k = table_model[SLOT_W'($urandom_range(first, last))];
        else if (pick < 80)
            k = table_model[SLOT_W'($urandom_range(0, 255))]
                + ($signed($urandom_range(0, 2)) - 1);
        else
            k = $urandom;
        send_op(act, '0, '0, k, first, last);
    endtask

    // Hits and misses on a short sorted run, extremes and duplicates included
    task automatic test_sorted_lookups();
        send_op(ACT_WRITE, 8'd0, 32'sh8000_0000, '0, '0, '0);
        send_op(ACT_WRITE, 8'd1, -32'sd5, '0, '0, '0);
        send_op(ACT_WRITE, 8'd2, -32'sd5, '0, '0, '0);
        send_op(ACT_WRITE, 8'd3, 32'sd0, '0, '0, '0);
        send_op(ACT_WRITE, 8'd4, 32'sd7, '0, '0, '0);
        send_op(ACT_WRITE, 8'd5, 32'sd7, '0, '0, '0);
        send_op(ACT_WRITE, 8'd6, 32'sd7, '0, '0, '0);
        send_op(ACT_WRITE, 8'd7, 32'sh7FFF_FFFF, '0, '0, '0);
        send_op(ACT_BSEARCH, '0, '0, 32'sh8000_0000, 8'd0, 8'd7);
        send_op(ACT_BSEARCH, '0, '0, 32'sh7FFF_FFFF, 8'd0, 8'd7);
        send_op(ACT_BSEARCH, '0, '0, 32'sd7, 8'd0, 8'd7);
        send_op(ACT_LSEARCH, '0, '0, 32'sd7, 8'd0, 8'd7);
        send_op(ACT_LSEARCH, '0, '0, -32'sd5, 8'd0, 8'd7);
        send_op(ACT_BSEARCH, '0, '0, 32'sd1, 8'd0, 8'd7);
        send_op(ACT_LSEARCH, '0, '0, 32'sd1, 8'd0, 8'd7);
    endtask

    // Top of the table, single-slot and empty ranges
    task automatic test_edge_ranges();
        send_op(ACT_WRITE, 8'd254, -32'sd1, '0, '0, '0);
        send_op(ACT_WRITE, 8'd255, 32'sh7FFF_FFFF, '0, '0, '0);
        send_op(ACT_BSEARCH, '0, '0, 32'sh7FFF_FFFF, 8'd254, 8'd255);
        send_op(ACT_LSEARCH, '0, '0, -32'sd1, 8'd255, 8'd255);
        send_op(ACT_BSEARCH, '0, '0, 32'sd7, 8'd5, 8'd4);
        send_op(ACT_LSEARCH, '0, '0, 32'sd7, 8'd255, 8'd0);
    endtask

    // Break the order so the binary probe misses a present key; drop action 3
    task automatic test_unsorted_and_ignored();
        send_op(ACT_WRITE, 8'd3, 32'sd100, '0, '0, '0);
        send_op(ACT_BSEARCH, '0, '0, 32'sd7, 8'd0, 8'd7);
        send_op(ACT_LSEARCH, '0, '0, 32'sd7, 8'd0, 8'd7);
        send_op(ACT_IGNORE, '0, '0, '0, '0, '0);
    endtask

    // Sorted fill followed by mostly searches, a few stray writes and dropped ops
    task automatic test_random_searches(input int item_count, input longint start_value,
                                        input int unsigned max_step, input int steady_items);
        int n;
        int pick;

        fill_sorted(start_value, max_step);
        for (n = 0; n < item_count; n++)
        begin
            steady = (n < steady_items);
            pick   = $urandom_range(0, 99);
            if (pick < 2)
            begin
                send_op(ACT_WRITE, SLOT_W'($urandom), FIELD_W'($urandom), '0, '0, '0);
            end
            else if (pick < 4)
            begin
                // Nudge a word, which may leave its neighbors out of order
                pick = $urandom_range(0, 255);
                send_op(ACT_WRITE, SLOT_W'(pick),
                        table_model[SLOT_W'(pick)] + ($signed($urandom_range(0, 4)) - 2),
                        '0, '0, '0);
            end
            else if (pick < 6)
            begin
                send_op(ACT_IGNORE, '0, '0, '0, '0, '0);
            end
            else
            begin
                random_search();
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.action       = ACT_WRITE;
        req_bus.slot         = '0;
        req_bus.entry_value  = '0;
        req_bus.key          = '0;
        req_bus.range_first  = '0;
        req_bus.range_last   = '0;
        resp_bus.ready       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_sorted_lookups();
        test_edge_ranges();
        test_unsorted_and_ignored();
        test_random_searches(450, -64'sd2147483648, 33554432, 0);
        test_random_searches(450, $signed($urandom), 3, 150);

        @(negedge clk);
        req_bus.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
